FILE: sv/positional_list_engine_assert.svh
// Assertion macros shared by the positional list engine RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/ple_pkg.sv
// Types and constants for the positional list engine.
// No dependencies; imported by ple_cell, positional_list_engine, ple_list_checker and tb.
`default_nettype none

package ple_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned CNT_OUT_W = 5;
	localparam int unsigned TYPE_W    = 3;

	typedef enum logic [TYPE_W-1:0] {
		REQ_INSERT   = 3'd0,
		REQ_REPLACE  = 3'd1,
		REQ_DELETE   = 3'd2,
		REQ_RETRIEVE = 3'd3,
		REQ_CLEAR    = 3'd4
	} req_code_t;

	typedef struct packed {
		logic [TYPE_W-1:0]        req_type;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data_out;
		logic                     request_error;
		logic [CNT_OUT_W-1:0]     entry_count;
		logic                     is_empty;
		logic                     is_full;
	} rsp_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic                     shift_up;
		logic                     shift_down;
		logic                     load;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/ple_cell.sv
// One slot of the list: holds an entry, takes its neighbour's on a shift.
// Depends on ple_pkg.
`default_nettype none

module ple_cell
	import ple_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input  wire logic                     clk,
	input  wire cell_ctl_t                ctl,
	input  wire logic signed [DATA_W-1:0] left,
	input  wire logic signed [DATA_W-1:0] right,
	output logic signed [DATA_W-1:0]      entry,
	output logic signed [DATA_W-1:0]      rd
);

	logic [31:0] pos_w;
	logic        at_pos;
	logic        above_pos;
	logic signed [DATA_W-1:0] entry_q;

	assign pos_w     = 32'(ctl.pos);
	assign at_pos    = (pos_w == IDX);
	assign above_pos = (IDX > pos_w);

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (ctl.shift_up && above_pos) begin
			entry_q <= left;
		end else if ((ctl.shift_up || ctl.load) && at_pos) begin
			entry_q <= ctl.value;
		end else if (ctl.shift_down && (above_pos || at_pos)) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;
	assign rd    = at_pos ? entry_q : '0;

endmodule

`default_nettype wire

FILE: sv/positional_list_engine.sv
// Top level of the positional list engine: control, count and a chain of cells.
// Depends on ple_pkg, ple_cell and positional_list_engine_assert.svh.
//
//  channel | signals                 | direction | item
//  --------+-------------------------+-----------+----------------------------
//  req     | req_valid, req_ready    | in        | req_t  (type, position, value)
//  rsp     | rsp_valid, rsp_ready    | out       | rsp_t  (data, error, count, flags)
//
// Each request reaches every cell through one broadcast; the result is registered
// and shows in the cycle after acceptance. One item per cycle sustained while rsp_ready
// is high; the figure is set by the single broadcast of control to the cell chain.
// Reset clears the count and the result valid; entries hold no reset.
// A held result stalls the input only when rsp_ready is low.
`default_nettype none

`include "positional_list_engine_assert.svh"

module positional_list_engine
	import ple_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cnt_d;
	logic [CMPW-1:0] pos_c;
	logic [CMPW-1:0] cnt_c;
	logic            full;
	logic            err;
	logic            take;
	logic            is_ins;
	logic            is_rep;
	logic            is_del;
	logic            is_ret;
	logic            is_clr;
	cell_ctl_t       ctl;
	logic signed [DATA_W-1:0] entry_a [CAPACITY];
	logic signed [DATA_W-1:0] rd_a    [CAPACITY];
	logic signed [DATA_W-1:0] rd_any;
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	assign take      = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;

	assign pos_c = CMPW'(req.position);
	assign cnt_c = CMPW'(cnt_q);
	assign full  = (cnt_q == CW'(CAPACITY));

	assign is_ins = (req.req_type == REQ_INSERT);
	assign is_rep = (req.req_type == REQ_REPLACE);
	assign is_del = (req.req_type == REQ_DELETE);
	assign is_ret = (req.req_type == REQ_RETRIEVE);
	assign is_clr = (req.req_type == REQ_CLEAR);

	// refusal: bad position, insert when full, unknown code
	always_comb begin
		case (req.req_type)
			REQ_INSERT:   err = (pos_c > cnt_c) || full;
			REQ_REPLACE,
			REQ_DELETE,
			REQ_RETRIEVE: err = (pos_c >= cnt_c);
			REQ_CLEAR:    err = 1'b0;
			default:      err = 1'b1;
		endcase
	end

	always_comb begin
		cnt_d = cnt_q;
		if (!err) begin
			if (is_ins) begin
				cnt_d = cnt_q + CW'(1);
			end else if (is_del) begin
				cnt_d = cnt_q - CW'(1);
			end else if (is_clr) begin
				cnt_d = '0;
			end
		end
	end

	assign ctl.shift_up   = take && !err && is_ins;
	assign ctl.shift_down = take && !err && is_del;
	assign ctl.load       = take && !err && is_rep;
	assign ctl.pos        = req.position;
	assign ctl.value      = req.value_in;

	// cell chain: insert pulls from the left, delete from the right
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = req.value_in;
		end else begin : g_mid_l
			assign left_d = entry_a[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = entry_a[i];
		end else begin : g_mid_r
			assign right_d = entry_a[i+1];
		end
		ple_cell #(
			.IDX (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.left  (left_d),
			.right (right_d),
			.entry (entry_a[i]),
			.rd    (rd_a[i])
		);
	end

	// only the addressed cell drives a non-zero read
	always_comb begin
		rd_any = '0;
		for (int unsigned i = 0; i < CAPACITY; i++) begin
			rd_any = rd_any | rd_a[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cnt_q       <= cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.data_out      <= (!err && (is_del || is_ret)) ? rd_any : '0;
			rsp_q.request_error <= err;
			rsp_q.entry_count   <= CNT_OUT_W'(cnt_d);
			rsp_q.is_empty      <= (cnt_d == '0);
			rsp_q.is_full       <= (cnt_d == CW'(CAPACITY));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PLE_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY), "count above capacity")
	`PLE_ASSERT_NEXT(a_err_hold, clk, arst_n, take && err, cnt_q == $past(cnt_q), "refused request changed count")
	`PLE_ASSERT_NEXT(a_ins_inc, clk, arst_n, take && !err && is_ins, cnt_q == $past(cnt_q) + CW'(1), "insert did not grow count")
	`PLE_ASSERT_NOW(a_ready_free, clk, arst_n, !rsp_valid_q, req_ready, "input stalled with empty result register")

endmodule

`default_nettype wire

FILE: sim/ple_list_checker.sv
// Result checker for the positional list engine: keeps its own list, predicts
// each result and compares it with the block's output. Depends on ple_pkg.
module ple_list_checker
	import ple_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending,
	output int   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PRINTED = 30;

	logic signed [DATA_W-1:0] list_entries [CAPACITY];
	int unsigned              list_len = 0;
	rsp_t                     awaited_results [$];
	int                       mismatches = 0;
	int                       pending_n = 0;
	int                       checked_n = 0;

	assign fail_count = mismatches;
	assign pending    = pending_n;
	assign checked    = checked_n;

	// Applies one request to the local list and returns the result it should give.
	function automatic rsp_t apply_list_request(input req_t r);
		rsp_t        res;
		int unsigned k;
		res = '0;
		case (r.req_type)
			REQ_INSERT: begin
				if (r.position > list_len || list_len >= CAPACITY) begin
					res.request_error = 1'b1;
				end else begin
					for (k = list_len; k > r.position; k--)
						list_entries[k] = list_entries[k-1];
					list_entries[r.position] = r.value_in;
					list_len++;
				end
			end
			REQ_REPLACE: begin
				if (r.position >= list_len)
					res.request_error = 1'b1;
				else
					list_entries[r.position] = r.value_in;
			end
			REQ_DELETE: begin
				if (r.position >= list_len) begin
					res.request_error = 1'b1;
				end else begin
					res.data_out = list_entries[r.position];
					for (k = r.position; k + 1 < list_len; k++)
						list_entries[k] = list_entries[k+1];
					list_len--;
				end
			end
			REQ_RETRIEVE: begin
				if (r.position >= list_len)
					res.request_error = 1'b1;
				else
					res.data_out = list_entries[r.position];
			end
			REQ_CLEAR: begin
				list_len = 0;
			end
			default: begin
				res.request_error = 1'b1;
			end
		endcase
		res.entry_count = CNT_OUT_W'(list_len);
		res.is_empty    = (list_len == 0);
		res.is_full     = (list_len == CAPACITY);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (mismatches < MAX_PRINTED)
			$display("%0t mismatch on result %0d, %s: got %0h, expected %0h",
				$realtime, checked_n, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			awaited_results.delete();
			list_len = 0;
		end else begin
			// Results first: one accepted in this cycle belongs to an older request.
			if (rsp_valid && rsp_ready) begin
				checked_n++;
				if (awaited_results.size() == 0) begin
					report_mismatch("result with nothing outstanding", rsp.data_out, '0);
				end else begin
					want = awaited_results.pop_front();
					if (rsp.data_out !== want.data_out)
						report_mismatch("data_out", rsp.data_out, want.data_out);
					if (rsp.request_error !== want.request_error)
						report_mismatch("request_error", DATA_W'(rsp.request_error),
							DATA_W'(want.request_error));
					if (rsp.entry_count !== want.entry_count)
						report_mismatch("entry_count", DATA_W'(rsp.entry_count),
							DATA_W'(want.entry_count));
					if (rsp.is_empty !== want.is_empty)
						report_mismatch("is_empty", DATA_W'(rsp.is_empty),
							DATA_W'(want.is_empty));
					if (rsp.is_full !== want.is_full)
						report_mismatch("is_full", DATA_W'(rsp.is_full),
							DATA_W'(want.is_full));
				end
			end
			if (req_valid && req_ready)
				awaited_results.push_back(apply_list_request(req));
		end
		pending_n = awaited_results.size();
	end

endmodule

FILE: sim/tb.sv
// Testbench top for the positional list engine: clock, reset, request and
// response traffic, verdict. Depends on ple_pkg, positional_list_engine, ple_list_checker.
module tb;
	import ple_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAPACITY     = 16;
	localparam int          RANDOM_ITEMS = 1200;
	localparam int          LONG_HOLD    = 90;    // receiver hold-off, in cycles
	localparam int          MAX_GAP      = 16;
	localparam int          LIMIT_CYCLES = 400000;
	localparam int          POS_MAX      = (1 << POS_W) - 1;

	// Codes with no request behind them; the block must refuse them.
	localparam logic [TYPE_W-1:0] REQ_UNUSED_LO = TYPE_W'(REQ_CLEAR + 1);
	localparam logic [TYPE_W-1:0] REQ_UNUSED_HI = '1;

	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef enum {FILLING, DRAINING, MIXING} traffic_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int fail_count;
	int pending;
	int checked;
	int cycle_count = 0;

	// Stimulus bookkeeping: a count-only shadow of the list, used to aim positions.
	int occupancy    = 0;
	int kind_seen [1 << TYPE_W];
	int full_reached = 0;
	int full_refused = 0;
	bit send_quiet   = 0;

	positional_list_engine #(.CAPACITY(CAPACITY)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	ple_list_checker #(.CAPACITY(CAPACITY)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offers one item after a random gap and returns at the edge it is taken.
	// Valid stays high on return; lower_valid drops it when no item follows at once.
	task automatic issue(input logic [TYPE_W-1:0] kind, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		int gap;
		gap = (send_quiet || $urandom_range(0, 1)) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{req_type: kind, position: pos, value_in: val};
		do @(posedge clk); while (!req_ready);

		kind_seen[kind]++;
		case (kind)
			REQ_INSERT: begin
				if (pos <= occupancy && occupancy < CAPACITY) begin
					occupancy++;
					if (occupancy == CAPACITY)
						full_reached++;
				end else if (occupancy == CAPACITY) begin
					full_refused++;
				end
			end
			REQ_DELETE: if (pos < occupancy) occupancy--;
			REQ_CLEAR:  occupancy = 0;
			default: ;
		endcase
	endtask

	task automatic lower_valid();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Extremes turn up often; the rest is spread over the whole range.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Response side: random stalls per item, quiet stretches, and two long
	// hold-offs during which the sender keeps offering, so the input stalls.
	initial begin : response_side
		int gap;
		int taken;
		bit recv_quiet;
		taken      = 0;
		recv_quiet = 0;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 50 == 0)
				recv_quiet = ($urandom_range(0, 2) == 0);
			if (taken == 250 || taken == 800)
				gap = LONG_HOLD;
			else if (recv_quiet || $urandom_range(0, 1))
				gap = 0;
			else
				gap = $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			taken++;
		end
	end

	initial begin : request_side
		traffic_t                 mode;
		int                       n;
		int                       i;
		int                       pick;
		int                       ins_cut;
		int                       del_cut;
		logic [TYPE_W-1:0]        kind;
		logic [POS_W-1:0]         pos;
		bit                       noise;

		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		foreach (kind_seen[k]) kind_seen[k] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every access on an empty list is refused, as are insert
		// past the end and the unused codes.
		issue(REQ_RETRIEVE, 0, '0);
		issue(REQ_DELETE, 0, '0);
		issue(REQ_REPLACE, 0, VAL_MAX);
		issue(REQ_INSERT, 1, VAL_MIN);
		issue(REQ_UNUSED_LO, POS_W'(POS_MAX), '1);
		issue(REQ_UNUSED_HI, POS_W'(CAPACITY), VAL_MIN);

		// Fill to capacity, inserting at the front, at the end and in the middle.
		for (i = 0; i < CAPACITY; i++) begin
			case (i % 3)
				0:       pos = 0;
				1:       pos = POS_W'(occupancy);
				default: pos = POS_W'(occupancy / 2);
			endcase
			case (i)
				0:       issue(REQ_INSERT, pos, VAL_MIN);
				1:       issue(REQ_INSERT, pos, VAL_MAX);
				2:       issue(REQ_INSERT, pos, '0);
				3:       issue(REQ_INSERT, pos, '1);
				default: issue(REQ_INSERT, pos, $urandom);
			endcase
		end

		// Full list: insert refused, last slot read, replaced, then gone after a delete.
		issue(REQ_INSERT, 3, VAL_MAX);
		issue(REQ_RETRIEVE, POS_W'(CAPACITY - 1), '0);
		issue(REQ_REPLACE, POS_W'(CAPACITY - 1), VAL_MIN);
		issue(REQ_DELETE, 0, '0);
		issue(REQ_RETRIEVE, POS_W'(CAPACITY - 1), '0);
		issue(REQ_CLEAR, 0, VAL_MAX);

		// Random: phases that mostly fill, mostly drain or mix, so the list
		// swings between empty and full; about one position in ten is noise.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				mode       = traffic_t'($urandom_range(0, 2));
				send_quiet = ($urandom_range(0, 3) == 0);
				case (mode)
					FILLING:  begin ins_cut = 55; del_cut = 65; end
					DRAINING: begin ins_cut = 15; del_cut = 65; end
					default:  begin ins_cut = 32; del_cut = 57; end
				endcase
			end
			// Halfway the sender pauses until every result is back.
			if (n == RANDOM_ITEMS / 2) begin
				lower_valid();
				wait (pending == 0);
				@(posedge clk);
			end

			pick = $urandom_range(0, 99);
			if (pick < ins_cut)
				kind = REQ_INSERT;
			else if (pick < del_cut)
				kind = REQ_DELETE;
			else if (pick < del_cut + 12)
				kind = REQ_REPLACE;
			else if (pick < del_cut + 27)
				kind = REQ_RETRIEVE;
			else if (pick < del_cut + 29)
				kind = REQ_CLEAR;
			else
				kind = TYPE_W'(REQ_UNUSED_LO
					+ $urandom_range(0, REQ_UNUSED_HI - REQ_UNUSED_LO));

			noise = ($urandom_range(0, 9) == 0);
			if (noise)
				pos = POS_W'($urandom_range(0, POS_MAX));
			else if (kind == REQ_INSERT)
				pos = POS_W'($urandom_range(0, occupancy));
			else if (occupancy == 0)
				pos = POS_W'($urandom_range(0, POS_MAX));
			else
				pos = POS_W'($urandom_range(0, occupancy - 1));

			issue(kind, pos, pick_value());
		end

		lower_valid();
		wait (pending == 0);
		repeat (4) @(posedge clk);

		$display("covered %0d requests: insert %0d, replace %0d, delete %0d, retrieve %0d,",
			checked, kind_seen[REQ_INSERT], kind_seen[REQ_REPLACE], kind_seen[REQ_DELETE],
			kind_seen[REQ_RETRIEVE]);
		$display("  clear %0d, unused codes %0d; list filled %0d times, %0d inserts refused when full",
			kind_seen[REQ_CLEAR], kind_seen[REQ_UNUSED_LO] + kind_seen[REQ_UNUSED_LO + 1]
			+ kind_seen[REQ_UNUSED_HI], full_reached, full_refused);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/ple_pkg.sv
sv/ple_cell.sv
sv/positional_list_engine.sv
sim/ple_list_checker.sv
sim/tb.sv
